@@ src/tptu_pkg.sv @@
// shared types and constants for the page translation unit
package tptu_pkg;

  localparam int TlbEntries  = 16;
  localparam int PageCount   = 256;
  localparam int FrameCount  = 64;
  localparam int OffsetWidth = 8;
  localparam int VaWidth     = 16;
  localparam int PaWidth     = 14;
  localparam int PageWidth   = 8;
  localparam int FrameWidth  = 6;
  localparam int TlbIdxWidth = 4;
  localparam int CountWidth  = 32;
  localparam int QueueDepth  = 2;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  // one classified request passed from the front to the back
  typedef struct packed {
    logic [PageWidth-1:0]   page;
    logic [OffsetWidth-1:0] offset;
    logic                   hit;
    logic [FrameWidth-1:0]  frame;
  } tptu_req_t;

  // one result item
  typedef struct packed {
    logic [PaWidth-1:0]    phys_addr;
    logic                  tlb_hit;
    logic                  page_fault;
    logic [PageWidth-1:0]  load_page;
    logic                  victim_valid;
    logic [PageWidth-1:0]  victim_page;
    logic [CountWidth-1:0] translation_count;
    logic [CountWidth-1:0] tlb_hit_count;
    logic [CountWidth-1:0] page_fault_count;
  } tptu_res_t;

  // tlb update sent from the back to the front
  typedef struct packed {
    logic                 fill;
    logic [PageWidth-1:0] fill_page;
    logic [FrameWidth-1:0] fill_frame;
    logic                 inval;
    logic [PageWidth-1:0] inval_page;
  } tptu_tlb_upd_t;

endpackage

@@ src/tptu_if.sv @@
// request and result channel interfaces
interface tptu_in_if ();
  logic                        valid;
  logic                        ready;
  logic [tptu_pkg::VaWidth-1:0] virtual_address;
  modport source (output valid, output virtual_address, input ready);
  modport sink (input valid, input virtual_address, output ready);
endinterface

interface tptu_out_if ();
  logic                 valid;
  logic                 ready;
  tptu_pkg::tptu_res_t  res;
  modport source (output valid, output res, input ready);
  modport sink (input valid, input res, output ready);
endinterface

@@ src/tlb_page_translation_unit.sv @@
// top level of the page translation unit
//  channel | direction | payload
//  in_     | sink      | virtual_address
//  out_    | source    | translation result
//  cfg_    | write     | replacement_policy
// request to result: a tlb hit or a free-frame fault passes S_IDLE and S_DONE; a
// page-table hit adds S_PT, a fifo victim S_VIC, S_OWN, S_CHK, and an lru fault also
// scans every frame's stamp in S_LRU first. the back holds one request; a result
// held in the output register lets it take the next, which waits in S_DONE.
// the front blocks after a tlb miss until the back refills the tlb.
// reset is synchronous, active low.
module tlb_page_translation_unit (
  input  logic        clk,
  input  logic        rst_n,
  tptu_in_if.sink     in_ch,
  tptu_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);
  logic policy_r;
  logic fq_valid, fq_ready, bq_valid, bq_ready;
  tptu_pkg::tptu_req_t fq_req, bq_req;
  tptu_pkg::tptu_tlb_upd_t upd;

  // policy register
  always_ff @(posedge clk) begin
    if (!rst_n) policy_r <= tptu_pkg::POLICY_FIFO;
    else if (cfg_we) policy_r <= cfg_wdata;
  end

  tptu_front u_front (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_virtual_address(in_ch.virtual_address),
    .q_valid(fq_valid), .q_req(fq_req), .q_ready(fq_ready), .upd
  );

  tptu_queue u_queue (
    .clk, .rst_n, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_req),
    .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_req)
  );

  tptu_back u_back (
    .clk, .rst_n, .cfg_policy(policy_r), .q_valid(bq_valid), .q_ready(bq_ready),
    .q_req(bq_req), .o_valid(out_ch.valid), .o_ready(out_ch.ready),
    .o_res(out_ch.res), .upd
  );
endmodule

@@ src/tptu_front.sv @@
// front: tlb lookup and classification of each request
module tptu_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tptu_pkg::VaWidth-1:0]  in_virtual_address,
  output logic                          q_valid,
  output tptu_pkg::tptu_req_t           q_req,
  input  logic                          q_ready,
  input  tptu_pkg::tptu_tlb_upd_t       upd
);

  logic [tptu_pkg::PageWidth-1:0]  tag_r [tptu_pkg::TlbEntries];
  logic [tptu_pkg::FrameWidth-1:0] frm_r [tptu_pkg::TlbEntries];
  logic [tptu_pkg::TlbEntries-1:0] vld_r;
  logic [tptu_pkg::TlbIdxWidth-1:0] fill_ptr_r;
  // after a tlb miss: busy until the back refills the tlb
  logic busy_r;
  logic [tptu_pkg::PageWidth-1:0] page;
  logic hit;
  logic [tptu_pkg::FrameWidth-1:0] hfrm;
  logic acc;

  assign page = in_virtual_address[tptu_pkg::VaWidth-1:tptu_pkg::OffsetWidth];
  assign in_ready = !busy_r && q_ready;
  assign acc = in_valid && in_ready;

  // associative match, lowest entry wins
  always_comb begin
    hit  = 1'b0;
    hfrm = '0;
    for (int i = tptu_pkg::TlbEntries - 1; i >= 0; i--) begin
      if (vld_r[i] && tag_r[i] == page) begin
        hit  = 1'b1;
        hfrm = frm_r[i];
      end
    end
  end

  assign q_valid       = acc;
  assign q_req.page    = page;
  assign q_req.offset  = in_virtual_address[tptu_pkg::OffsetWidth-1:0];
  assign q_req.hit     = hit;
  assign q_req.frame   = hfrm;

  // tlb storage and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      fill_ptr_r <= '0;
      busy_r     <= 1'b0;
    end else begin
      if (acc && !hit) busy_r <= 1'b1;
      if (upd.fill) busy_r <= 1'b0;
      if (upd.inval) begin
        for (int i = 0; i < tptu_pkg::TlbEntries; i++) begin
          if (tag_r[i] == upd.inval_page) vld_r[i] <= 1'b0;
        end
      end
      if (upd.fill) begin
        tag_r[fill_ptr_r] <= upd.fill_page;
        frm_r[fill_ptr_r] <= upd.fill_frame;
        vld_r[fill_ptr_r] <= 1'b1;
        fill_ptr_r        <= fill_ptr_r + 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_ready) else $error("accept while miss pending");
  a_fill_clears: assert property (@(posedge clk) disable iff (!rst_n)
    upd.fill |=> !busy_r) else $error("busy not cleared by fill");
  a_miss_sets: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !hit && !upd.fill) |=> busy_r) else $error("miss did not block");
`endif

endmodule

@@ src/tptu_queue.sv @@
// short request queue between front and back
module tptu_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  tptu_pkg::tptu_req_t wr_data,
  output logic                rd_valid,
  input  logic                rd_ready,
  output tptu_pkg::tptu_req_t rd_data
);
  localparam int AW = $clog2(tptu_pkg::QueueDepth);
  tptu_pkg::tptu_req_t mem_r [tptu_pkg::QueueDepth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic wr, rd;

  assign wr_ready = cnt_r != AW'(0) + (AW+1)'(tptu_pkg::QueueDepth);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  // pointers and storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) begin
        mem_r[wp_r] <= wr_data;
        wp_r <= wp_r + 1'b1;
      end
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(tptu_pkg::QueueDepth)) else $error("queue overflow");
`endif
endmodule

@@ src/tptu_back.sv @@
// back: page table, frame allocation, replacement and statistics
module tptu_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_policy,
  input  logic                    q_valid,
  output logic                    q_ready,
  input  tptu_pkg::tptu_req_t     q_req,
  output logic                    o_valid,
  input  logic                    o_ready,
  output tptu_pkg::tptu_res_t     o_res,
  output tptu_pkg::tptu_tlb_upd_t upd
);
  localparam int FW = tptu_pkg::FrameWidth;
  localparam int PW = tptu_pkg::PageWidth;
  localparam int CW = tptu_pkg::CountWidth;

  typedef enum logic [2:0] {S_IDLE, S_PT, S_LRU, S_VIC, S_OWN, S_CHK, S_DONE} state_t;
  state_t state_r;

  logic [tptu_pkg::PageCount-1:0] mapped_r;
  logic [FW-1:0] pframe_mem [tptu_pkg::PageCount];
  logic [PW-1:0] owner_mem [tptu_pkg::FrameCount];
  logic [CW-1:0] last_mem [tptu_pkg::FrameCount];
  logic [FW:0]   in_use_r;
  logic [FW-1:0] fifo_ptr_r;
  logic [CW-1:0] time_r, cnt_tr_r, cnt_hit_r, cnt_pf_r;
  tptu_pkg::tptu_req_t req_r;
  logic [FW-1:0] frame_r, best_r;
  logic [FW:0]   scan_r;
  logic [CW-1:0] best_t_r;
  logic [FW-1:0] pf_rd_r;
  logic [PW-1:0] own_rd_r;
  logic [CW-1:0] last_rd_r;
  logic fault_r, vv_r;
  logic [PW-1:0] vpage_r;
  logic out_v_r;
  tptu_pkg::tptu_res_t res_r;
  logic [PW-1:0] pf_addr;
  logic [FW-1:0] lru_cand;
  logic lru_take;
  logic vic_hit;
  logic res_load;

  assign q_ready = state_r == S_IDLE;
  assign o_valid = out_v_r;
  assign o_res   = res_r;

  // page-table read address: incoming page when idle, else victim owner
  assign pf_addr  = (state_r == S_IDLE) ? q_req.page : own_rd_r;
  // lru candidate whose stamp sits in last_rd_r
  assign lru_cand = scan_r[FW-1:0] - FW'(1);
  assign lru_take = (scan_r == (FW+1)'(1)) || (last_rd_r < best_t_r);
  // victim frame still owned by a mapped page
  assign vic_hit  = mapped_r[own_rd_r] && pf_rd_r == frame_r;
  // result register free or emptied at this edge
  assign res_load = state_r == S_DONE && (!out_v_r || o_ready);

  function automatic logic [CW-1:0] sat(input logic [CW-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // registered memory reads
  always_ff @(posedge clk) begin
    pf_rd_r   <= pframe_mem[pf_addr];
    own_rd_r  <= owner_mem[frame_r];
    last_rd_r <= last_mem[scan_r[FW-1:0]];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; mapped_r <= '0; in_use_r <= '0; fifo_ptr_r <= '0;
      time_r <= '0; cnt_tr_r <= '0; cnt_hit_r <= '0; cnt_pf_r <= '0;
      out_v_r <= 1'b0; upd <= '0;
    end else begin
      // tlb refill after a miss, invalidation of an evicted page
      upd.fill       <= res_load && !req_r.hit;
      upd.fill_page  <= req_r.page;
      upd.fill_frame <= frame_r;
      upd.inval      <= state_r == S_CHK && vic_hit;
      upd.inval_page <= own_rd_r;
      out_v_r        <= res_load || (out_v_r && !o_ready);
      case (state_r)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            req_r    <= q_req;
            time_r   <= sat(time_r);
            cnt_tr_r <= sat(cnt_tr_r);
            fault_r  <= !q_req.hit && !mapped_r[q_req.page];
            vv_r <= 1'b0; vpage_r <= '0;
            if (q_req.hit) begin
              cnt_hit_r <= sat(cnt_hit_r);
              frame_r   <= q_req.frame;
              state_r   <= S_DONE;
            end else if (mapped_r[q_req.page]) begin
              state_r <= S_PT;
            end else begin
              cnt_pf_r <= sat(cnt_pf_r);
              if (in_use_r < (FW+1)'(tptu_pkg::FrameCount)) begin
                frame_r  <= in_use_r[FW-1:0];
                in_use_r <= in_use_r + 1'b1;
                state_r  <= S_DONE;
              end else if (cfg_policy == tptu_pkg::POLICY_FIFO) begin
                frame_r    <= fifo_ptr_r;
                fifo_ptr_r <= fifo_ptr_r + 1'b1;
                state_r    <= S_VIC;
              end else begin
                scan_r   <= '0;
                best_r   <= '0;
                best_t_r <= '1;
                frame_r  <= '0;
                state_r  <= S_LRU;
              end
            end
          end
        end
        S_PT: begin
          frame_r <= pf_rd_r;
          state_r <= S_DONE;
        end
        S_LRU: begin
          // one frame compared per cycle, registered read data trails the scan index by one frame
          scan_r <= scan_r + 1'b1;
          if (scan_r != '0 && lru_take) begin
            best_t_r <= last_rd_r;
            best_r   <= lru_cand;
          end
          if (scan_r == (FW+1)'(tptu_pkg::FrameCount)) begin
            frame_r <= lru_take ? lru_cand : best_r;
            state_r <= S_VIC;
          end
        end
        S_VIC: begin
          // owner of the victim frame being read
          state_r <= S_OWN;
        end
        S_OWN: begin
          // page-frame entry of the owner being read
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (vic_hit) begin
            vv_r    <= 1'b1;
            vpage_r <= own_rd_r;
            mapped_r[own_rd_r] <= 1'b0;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (res_load) begin
            if (fault_r) begin
              mapped_r[req_r.page]   <= 1'b1;
              pframe_mem[req_r.page] <= frame_r;
              owner_mem[frame_r]     <= req_r.page;
            end
            last_mem[frame_r] <= time_r;
            res_r.phys_addr         <= {frame_r, req_r.offset};
            res_r.tlb_hit           <= req_r.hit;
            res_r.page_fault        <= fault_r;
            res_r.load_page         <= fault_r ? req_r.page : '0;
            res_r.victim_valid      <= vv_r;
            res_r.victim_page       <= vpage_r;
            res_r.translation_count <= cnt_tr_r;
            res_r.tlb_hit_count     <= cnt_hit_r;
            res_r.page_fault_count  <= cnt_pf_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !o_ready) |=> (out_v_r && $stable(res_r))) else $error("result dropped");
  a_fill_done: assert property (@(posedge clk) disable iff (!rst_n)
    upd.fill |-> out_v_r) else $error("fill without result");
  a_inuse: assert property (@(posedge clk) disable iff (!rst_n)
    in_use_r <= (FW+1)'(tptu_pkg::FrameCount)) else $error("frame count");
`endif
endmodule
